FILE: design/sorted_key_table_assert.svh
// Assertion macros used by the verification files of the sorted key table.
// Each macro expects a signal named clk, and SKT_ASSERT also rst_n, in the scope where it is used.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Checked only while the block is out of reset.
`define SKT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SKT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/skt_pkg.sv
// Package for the sorted key table: command and status codes, item types and
// the controller/datapath interface structs. No dependencies.
package skt_pkg;

    // Default sizing of the table.
    localparam int CAPACITY_DEFAULT = 16;
    localparam int KEY_BITS_DEFAULT = 32;

    // Command codes.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [2:0] STATUS_OK     = 3'd0;
    localparam logic [2:0] STATUS_DUP    = 3'd1;
    localparam logic [2:0] STATUS_MISS   = 3'd2;
    localparam logic [2:0] STATUS_FULL   = 3'd3;
    localparam logic [2:0] STATUS_BADPOS = 3'd4;

    // One request item.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [3:0]  position;
    } req_t;

    // One result item.
    typedef struct packed {
        logic [2:0] status;
        logic [4:0] slot;
        logic [4:0] entry_total;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;       // capture the request, start a search
        logic       clear;      // empty the table
        logic       probe;      // read the middle entry of the search window
        logic       go_right;   // key above probed entry
        logic       go_left;    // key below probed entry
        logic       hit;        // key equals probed entry
        logic       miss;       // search ended, slot is the insertion point
        logic       up_init;    // start opening a gap
        logic       mv_rd_up;   // read the entry below the pointer
        logic       mv_wr_up;   // write it one slot up
        logic       ins_wr;     // write the new key into the gap
        logic       dn_init;    // start closing a gap
        logic       mv_rd_dn;   // read the entry above the pointer
        logic       mv_wr_dn;   // write it one slot down
        logic       cnt_dec;    // one entry removed
        logic       set_status;
        logic [2:0] status;
        logic       rsp_load;   // move the finished result to the output
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lo_lt_hi;
        logic key_eq;
        logic key_gt;
        logic full;
        logic up_more;
        logic dn_more;
        logic pos_bad;
        logic rsp_free;
    } ctl_stat_t;

endpackage

FILE: design/skt_dp.sv
// Datapath of the sorted key table: key memory, search window, move pointer,
// entry count and output register. Depends on skt_pkg.
module skt_dp #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT,
    parameter int KEY_BITS = skt_pkg::KEY_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  skt_pkg::req_t       req,
    input  skt_pkg::ctl_cmd_t   cmd,
    output skt_pkg::ctl_stat_t  stat,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output skt_pkg::rsp_t       rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = (CW > 4) ? CW : 4;

    logic [KEY_BITS-1:0] mem [CAPACITY];
    logic [KEY_BITS-1:0] rd_data_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       lo_reg;
    logic [CW-1:0]       hi_reg;
    logic [CW-1:0]       mid_reg;
    logic [CW-1:0]       ptr_reg;
    logic [SW-1:0]       slot_reg;
    logic [2:0]          status_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    skt_pkg::rsp_t       rsp_reg;

    logic [63:0]         key_wide;
    logic [CW:0]         mid_sum;
    logic [CW-1:0]       mid_next;
    logic [CW-1:0]       ptr_dec;
    logic [CW:0]         ptr_inc;
    logic [31:0]         slot_wide;
    logic [31:0]         total_wide;
    logic                mem_re;
    logic                mem_we;
    logic [AW-1:0]       mem_raddr;
    logic [AW-1:0]       mem_waddr;
    logic [KEY_BITS-1:0] mem_wdata;

    // Arithmetic on the search window and the move pointer.
    assign key_wide   = 64'(req.key);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_next   = mid_sum[CW:1];
    assign ptr_dec    = ptr_reg - CW'(1);
    assign ptr_inc    = {1'b0, ptr_reg} + (CW + 1)'(1);
    assign slot_wide  = 32'(slot_reg);
    assign total_wide = 32'(count_reg);

    // Status back to the controller.
    always_comb
    begin
        stat.lo_lt_hi = lo_reg < hi_reg;
        stat.key_eq   = key_reg == rd_data_reg;
        stat.key_gt   = key_reg > rd_data_reg;
        stat.full     = count_reg == CW'(CAPACITY);
        stat.up_more  = SW'(ptr_reg) > slot_reg;
        stat.dn_more  = ptr_inc < {1'b0, count_reg};
        stat.pos_bad  = slot_reg >= SW'(count_reg);
        stat.rsp_free = !rsp_valid_reg || rsp_ready;
    end

    // Memory port selection: one read and one write address per cycle.
    always_comb
    begin
        mem_re    = cmd.probe || cmd.mv_rd_up || cmd.mv_rd_dn;
        mem_we    = cmd.mv_wr_up || cmd.mv_wr_dn || cmd.ins_wr;
        mem_waddr = cmd.ins_wr ? slot_reg[AW-1:0] : ptr_reg[AW-1:0];
        mem_wdata = cmd.ins_wr ? key_reg : rd_data_reg;
        if (cmd.probe)
        begin
            mem_raddr = mid_next[AW-1:0];
        end
        else if (cmd.mv_rd_up)
        begin
            mem_raddr = ptr_dec[AW-1:0];
        end
        else
        begin
            mem_raddr = ptr_inc[AW-1:0];
        end
    end

    // Key memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Entry count.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.ins_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Output valid flag: set when a result is loaded, cleared when taken.
    assign rsp_valid_next = cmd.rsp_load || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Search window, move pointer, slot and status of the item in work.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key_wide[KEY_BITS-1:0];
            lo_reg   <= '0;
            hi_reg   <= count_reg;
            slot_reg <= (req.cmd == skt_pkg::CMD_DELETE) ? SW'(req.position) : '0;
        end
        if (cmd.probe)
        begin
            mid_reg <= mid_next;
        end
        if (cmd.go_right)
        begin
            lo_reg <= mid_reg + CW'(1);
        end
        if (cmd.go_left)
        begin
            hi_reg <= mid_reg;
        end
        if (cmd.hit)
        begin
            slot_reg <= SW'(mid_reg);
        end
        if (cmd.miss)
        begin
            slot_reg <= SW'(lo_reg);
        end
        if (cmd.up_init)
        begin
            ptr_reg <= count_reg;
        end
        if (cmd.dn_init)
        begin
            ptr_reg <= slot_reg[CW-1:0];
        end
        if (cmd.mv_wr_up)
        begin
            ptr_reg <= ptr_dec;
        end
        if (cmd.mv_wr_dn)
        begin
            ptr_reg <= ptr_inc[CW-1:0];
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.slot        <= slot_wide[4:0];
            rsp_reg.entry_total <= total_wide[4:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: design/skt_ctrl.sv
// Controller of the sorted key table: sequences search, gap moves and result
// hand-off for one item at a time. Depends on skt_pkg.
module skt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_cmd,
    output logic               req_ready,
    input  skt_pkg::ctl_stat_t stat,
    output skt_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PROBE = 9'b000000010,
        S_CMP   = 9'b000000100,
        S_UP_RD = 9'b000001000,
        S_UP_WR = 9'b000010000,
        S_DEL   = 9'b000100000,
        S_DN_RD = 9'b001000000,
        S_DN_WR = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] op_reg;
    logic [1:0] op_next;

    // Next state and datapath commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    op_next  = req_cmd;
                    unique case (req_cmd) inside
                        skt_pkg::CMD_INSERT, skt_pkg::CMD_FIND:
                        begin
                            state_next = S_PROBE;
                        end
                        skt_pkg::CMD_DELETE:
                        begin
                            state_next = S_DEL;
                        end
                        skt_pkg::CMD_CLEAR:
                        begin
                            cmd.clear      = 1'b1;
                            cmd.set_status = 1'b1;
                            cmd.status     = skt_pkg::STATUS_OK;
                            state_next     = S_FIN;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                if (stat.lo_lt_hi)
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    // Search exhausted: the slot is the insertion point.
                    cmd.miss = 1'b1;
                    if (op_reg == skt_pkg::CMD_FIND)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = skt_pkg::STATUS_MISS;
                        state_next     = S_FIN;
                    end
                    else if (stat.full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = skt_pkg::STATUS_FULL;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        cmd.up_init = 1'b1;
                        state_next  = S_UP_RD;
                    end
                end
            end
            S_CMP:
            begin
                if (stat.key_eq)
                begin
                    cmd.hit        = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = (op_reg == skt_pkg::CMD_INSERT) ?
                                     skt_pkg::STATUS_DUP : skt_pkg::STATUS_OK;
                    state_next     = S_FIN;
                end
                else if (stat.key_gt)
                begin
                    cmd.go_right = 1'b1;
                    state_next   = S_PROBE;
                end
                else
                begin
                    cmd.go_left = 1'b1;
                    state_next  = S_PROBE;
                end
            end
            S_UP_RD:
            begin
                if (stat.up_more)
                begin
                    cmd.mv_rd_up = 1'b1;
                    state_next   = S_UP_WR;
                end
                else
                begin
                    cmd.ins_wr     = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = skt_pkg::STATUS_OK;
                    state_next     = S_FIN;
                end
            end
            S_UP_WR:
            begin
                cmd.mv_wr_up = 1'b1;
                state_next   = S_UP_RD;
            end
            S_DEL:
            begin
                if (stat.pos_bad)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = skt_pkg::STATUS_BADPOS;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.dn_init = 1'b1;
                    state_next  = S_DN_RD;
                end
            end
            S_DN_RD:
            begin
                if (stat.dn_more)
                begin
                    cmd.mv_rd_dn = 1'b1;
                    state_next   = S_DN_WR;
                end
                else
                begin
                    cmd.cnt_dec    = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = skt_pkg::STATUS_OK;
                    state_next     = S_FIN;
                end
            end
            S_DN_WR:
            begin
                cmd.mv_wr_dn = 1'b1;
                state_next   = S_DN_RD;
            end
            S_FIN:
            begin
                // Wait until the output register can take the result.
                if (stat.rsp_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and latched command code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= skt_pkg::CMD_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

FILE: design/sorted_key_table.sv
// Top level of the sorted key table: controller plus datapath.
// Depends on skt_pkg, skt_ctrl and skt_dp.
//
// Keeps up to CAPACITY unsigned keys in ascending order in a memory with one
// read port and one write port, and serves one item at a time. Each item yields
// one result. Every item is accepted in S_IDLE and ends by loading the output
// register in S_FIN. Insert and find run a binary search in which each probe is
// a memory read, then a compare, with at most ceil(log2(count+1)) probes. A
// search that ends without a match records the insertion point. Insert then
// opens a gap by moving count - slot entries up, each by a read and a write,
// and then writes the key. Delete checks the position against the range, then
// closes the gap by moving count - 1 - position entries down, each by a read
// and a write, and then lowers the count. Clear takes no search. The final
// state of an item lasts until the output register is free. The output
// register lets the next item be accepted while a result still waits on
// rsp_ready. No clearing pass follows reset.
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT,
    parameter int KEY_BITS = skt_pkg::KEY_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  skt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output skt_pkg::rsp_t rsp
);

    skt_pkg::ctl_cmd_t  ctl_cmd;
    skt_pkg::ctl_stat_t ctl_stat;

    // Sequencer.
    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.cmd),
        .req_ready (req_ready),
        .stat      (ctl_stat),
        .cmd       (ctl_cmd)
    );

    // Storage and arithmetic.
    skt_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (ctl_cmd),
        .stat      (ctl_stat),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

FILE: design/skt_checker.sv
// Port-level checks for the sorted key table, bound to the top level.
// Depends on skt_pkg and sorted_key_table_assert.svh.
`include "sorted_key_table_assert.svh"

module skt_checker #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input skt_pkg::rsp_t rsp
);

    // No result is offered while reset is applied.
    `SKT_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !rsp_valid, "result valid during reset")

    // A stalled result item holds.
    `SKT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "stalled result changed")

    // The count never passes the capacity.
    `SKT_ASSERT(a_total_cap, rsp_valid |-> 32'(rsp.entry_total) <= 32'(CAPACITY), "entry total above capacity")

    // A full refusal only happens with the table at capacity.
    `SKT_ASSERT(a_full_total, rsp_valid && rsp.status == skt_pkg::STATUS_FULL |-> rsp.entry_total == 5'(CAPACITY), "full reported below capacity")

    // A bad position lies at or past the end of the table.
    `SKT_ASSERT(a_badpos_slot, rsp_valid && rsp.status == skt_pkg::STATUS_BADPOS |-> rsp.slot >= rsp.entry_total, "bad position inside table")

endmodule

bind sorted_key_table skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
